// ----- rtl/core/pbsc_pkg.sv -----
// Package for the byte-square Playfair block: geometry, function and status codes.
// No dependencies; used by playfair_byte_square_cipher.
package pbsc_pkg;

  localparam int ROWS   = 14;
  localparam int COLS   = 16;
  localparam int CELLS  = ROWS * COLS;
  localparam int CELL_W = 8;
  localparam int ROW_W  = 4;
  localparam int COL_W  = 4;

  localparam logic [7:0] FIRST_BYTE = 8'd32;

  localparam logic [2:0] FN_BEGIN = 3'd0;
  localparam logic [2:0] FN_KEY   = 3'd1;
  localparam logic [2:0] FN_CLOSE = 3'd2;
  localparam logic [2:0] FN_ENC   = 3'd3;
  localparam logic [2:0] FN_DEC   = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_PHASE = 2'd2;

endpackage

// ----- rtl/core/pbsc_ram.sv -----
// Generic RAM: one write port, two read ports with registered read data.
// No dependencies.
module pbsc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 224
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a_r <= mem[raddr_a];
    rdata_b_r <= mem[raddr_b];
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

// ----- rtl/core/playfair_byte_square_cipher.sv -----
// Top level of the byte-square Playfair cipher (14 x 16 square of bytes 32..255).
// Depends on pbsc_pkg and pbsc_ram.
//
// One item is in work at a time. The position RAM keeps a used mark beside each cell
// index. A clearing pass zeroes those marks after reset, with in_ready low, and again
// on every begin-key item. Before its result reaches the output register, a begin key
// waits on the clearing pass and a key byte on the read of its used mark. Close key
// walks over all 224 values, one per cycle. Encrypt and decrypt pairs wait on two
// dependent reads: the position RAM, then the square RAM. A phase or range error needs
// no RAM read. The next item is accepted as soon as the previous result has moved into
// the output register; a result still waiting there holds the block.
module playfair_byte_square_cipher (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [2:0] in_func,
  input  logic [7:0] in_byte_a,
  input  logic [7:0] in_byte_b,
  input  logic       in_pad_tail,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_a,
  output logic [7:0] out_b,
  output logic [1:0] out_status
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_EXEC  = 9'b000000010,
    S_KEY   = 9'b000000100,
    S_LOOK  = 9'b000001000,
    S_FETCH = 9'b000010000,
    S_FILL  = 9'b000100000,
    S_CLEAR = 9'b001000000,
    S_BOOT  = 9'b010000000,
    S_DONE  = 9'b100000000
  } state_t;

  localparam int AW = pbsc_pkg::CELL_W;

  state_t state_r, state_nxt;
  logic [2:0] func_r, func_nxt;
  logic [7:0] a_r, a_nxt;
  logic [7:0] b_r, b_nxt;
  logic [7:0] res_a_r, res_a_nxt;
  logic [7:0] res_b_r, res_b_nxt;
  logic [1:0] res_st_r, res_st_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [7:0] out_a_r, out_a_nxt;
  logic [7:0] out_b_r, out_b_nxt;
  logic [1:0] out_st_r, out_st_nxt;
  logic [AW-1:0] fill_r, fill_nxt;
  logic [AW-1:0] walk_r, walk_nxt;
  logic          ready_r, ready_nxt;

  logic          place_en;
  logic          clr_en;
  logic [AW-1:0] place_idx;
  logic [AW-1:0] a_idx, b_idx;

  logic          cob_we;
  logic [AW:0]   cob_wdata;
  logic [AW-1:0] cob_raddr_a, cob_raddr_b;
  logic [AW:0]   cob_rdata_a, cob_rdata_b;
  logic [AW-1:0] boc_raddr_a, boc_raddr_b;
  logic [7:0]    boc_rdata_a, boc_rdata_b;

  logic [pbsc_pkg::ROW_W-1:0] rowa, rowb, na_r, nb_r;
  logic [pbsc_pkg::COL_W-1:0] cola, colb, na_c, nb_c;
  logic                       enc;

  function automatic logic [pbsc_pkg::ROW_W-1:0] row_step(
    input logic [pbsc_pkg::ROW_W-1:0] row,
    input logic                       fwd
  );
    logic [pbsc_pkg::ROW_W-1:0] res;
    if (fwd) begin
      res = (row == pbsc_pkg::ROW_W'(pbsc_pkg::ROWS - 1)) ? '0 : row + 1'b1;
    end else begin
      res = (row == '0) ? pbsc_pkg::ROW_W'(pbsc_pkg::ROWS - 1) : row - 1'b1;
    end
    return res;
  endfunction

  // entry: {used mark, cell index}
  pbsc_ram #(.WIDTH(AW + 1), .DEPTH(pbsc_pkg::CELLS)) u_cell_of_byte (
    .clk     (clk),
    .we      (cob_we),
    .waddr   (place_idx),
    .wdata   (cob_wdata),
    .raddr_a (cob_raddr_a),
    .raddr_b (cob_raddr_b),
    .rdata_a (cob_rdata_a),
    .rdata_b (cob_rdata_b)
  );

  pbsc_ram #(.WIDTH(8), .DEPTH(pbsc_pkg::CELLS)) u_byte_of_cell (
    .clk     (clk),
    .we      (place_en),
    .waddr   (fill_r),
    .wdata   (place_idx + pbsc_pkg::FIRST_BYTE),
    .raddr_a (boc_raddr_a),
    .raddr_b (boc_raddr_b),
    .rdata_a (boc_rdata_a),
    .rdata_b (boc_rdata_b)
  );

  assign a_idx = a_r - pbsc_pkg::FIRST_BYTE;
  assign b_idx = b_r - pbsc_pkg::FIRST_BYTE;
  assign enc   = (func_r == pbsc_pkg::FN_ENC);

  assign rowa = cob_rdata_a[AW-1 -: pbsc_pkg::ROW_W];
  assign cola = cob_rdata_a[pbsc_pkg::COL_W-1:0];
  assign rowb = cob_rdata_b[AW-1 -: pbsc_pkg::ROW_W];
  assign colb = cob_rdata_b[pbsc_pkg::COL_W-1:0];

  always_comb begin
    na_r = rowa;
    nb_r = rowb;
    if (rowa == rowb) begin
      na_c = enc ? cola + 1'b1 : cola - 1'b1;
      nb_c = enc ? colb + 1'b1 : colb - 1'b1;
    end else if (cola == colb) begin
      na_c = cola;
      nb_c = colb;
      na_r = row_step(rowa, enc);
      nb_r = row_step(rowb, enc);
    end else begin
      na_c = colb;
      nb_c = cola;
    end
  end

  assign cob_we    = place_en || clr_en;
  assign cob_wdata = clr_en ? '0 : {1'b1, fill_r};

  always_comb begin
    state_nxt     = state_r;
    func_nxt      = func_r;
    a_nxt         = a_r;
    b_nxt         = b_r;
    res_a_nxt     = res_a_r;
    res_b_nxt     = res_b_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_a_nxt     = out_a_r;
    out_b_nxt     = out_b_r;
    out_st_nxt    = out_st_r;
    fill_nxt      = fill_r;
    walk_nxt      = walk_r;
    ready_nxt     = ready_r;
    place_en      = 1'b0;
    clr_en        = 1'b0;
    place_idx     = a_idx;
    cob_raddr_a   = a_idx;
    cob_raddr_b   = b_idx;
    boc_raddr_a   = {na_r, na_c};
    boc_raddr_b   = {nb_r, nb_c};

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          func_nxt  = in_func;
          a_nxt     = in_byte_a;
          b_nxt     = in_pad_tail ? pbsc_pkg::FIRST_BYTE : in_byte_b;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        res_a_nxt  = '0;
        res_b_nxt  = '0;
        res_st_nxt = pbsc_pkg::ST_OK;
        state_nxt  = S_DONE;
        unique case (func_r) inside
          pbsc_pkg::FN_BEGIN: begin
            fill_nxt  = '0;
            ready_nxt = 1'b0;
            walk_nxt  = '0;
            state_nxt = S_CLEAR;
          end
          pbsc_pkg::FN_KEY: begin
            if (ready_r) begin
              res_st_nxt = pbsc_pkg::ST_PHASE;
            end else if (a_r < pbsc_pkg::FIRST_BYTE) begin
              res_st_nxt = pbsc_pkg::ST_RANGE;
            end else begin
              state_nxt = S_KEY;
            end
          end
          pbsc_pkg::FN_CLOSE: begin
            if (ready_r) begin
              res_st_nxt = pbsc_pkg::ST_PHASE;
            end else begin
              walk_nxt    = '0;
              cob_raddr_a = '0;
              state_nxt   = S_FILL;
            end
          end
          pbsc_pkg::FN_ENC, pbsc_pkg::FN_DEC: begin
            if (!ready_r) begin
              res_st_nxt = pbsc_pkg::ST_PHASE;
            end else if (a_r < pbsc_pkg::FIRST_BYTE || b_r < pbsc_pkg::FIRST_BYTE) begin
              res_st_nxt = pbsc_pkg::ST_RANGE;
            end else begin
              state_nxt = S_LOOK;
            end
          end
          default: begin
            res_st_nxt = pbsc_pkg::ST_PHASE;
          end
        endcase
      end
      S_KEY: begin
        if (!cob_rdata_a[AW] && fill_r < AW'(pbsc_pkg::CELLS)) begin
          place_en = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        state_nxt = S_DONE;
      end
      S_LOOK: begin
        state_nxt = S_FETCH;
      end
      S_FETCH: begin
        res_a_nxt = boc_rdata_a;
        res_b_nxt = boc_rdata_b;
        state_nxt = S_DONE;
      end
      S_FILL: begin
        // read one value ahead of the one being placed
        place_idx   = walk_r;
        cob_raddr_a = (walk_r == AW'(pbsc_pkg::CELLS - 1)) ? walk_r : walk_r + 1'b1;
        if (!cob_rdata_a[AW] && fill_r < AW'(pbsc_pkg::CELLS)) begin
          place_en = 1'b1;
          fill_nxt = fill_r + 1'b1;
        end
        walk_nxt = walk_r + 1'b1;
        if (walk_r == AW'(pbsc_pkg::CELLS - 1)) begin
          ready_nxt = 1'b1;
          state_nxt = S_DONE;
        end
      end
      S_CLEAR: begin
        clr_en    = 1'b1;
        place_idx = walk_r;
        walk_nxt  = walk_r + 1'b1;
        if (walk_r == AW'(pbsc_pkg::CELLS - 1)) begin
          state_nxt = S_DONE;
        end
      end
      S_BOOT: begin
        clr_en    = 1'b1;
        place_idx = walk_r;
        walk_nxt  = walk_r + 1'b1;
        if (walk_r == AW'(pbsc_pkg::CELLS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_a_nxt     = res_a_r;
          out_b_nxt     = res_b_r;
          out_st_nxt    = res_st_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BOOT;
      out_valid_r <= 1'b0;
      fill_r      <= '0;
      walk_r      <= '0;
      ready_r     <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      fill_r      <= fill_nxt;
      walk_r      <= walk_nxt;
      ready_r     <= ready_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r   <= func_nxt;
    a_r      <= a_nxt;
    b_r      <= b_nxt;
    res_a_r  <= res_a_nxt;
    res_b_r  <= res_b_nxt;
    res_st_r <= res_st_nxt;
    out_a_r  <= out_a_nxt;
    out_b_r  <= out_b_nxt;
    out_st_r <= out_st_nxt;
  end

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_a      = out_a_r;
  assign out_b      = out_b_r;
  assign out_status = out_st_r;

  // one item in work at a time
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != pbsc_pkg::ST_OK |-> out_a == '0 && out_b == '0)
    else $error("nonzero bytes on error result");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= AW'(pbsc_pkg::CELLS))
    else $error("fill position past end of square");

  a_ready_full: assert property (@(posedge clk) disable iff (!rst_n)
    ready_r |-> fill_r == AW'(pbsc_pkg::CELLS))
    else $error("square ready but not full");

  a_look_placed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_LOOK |-> cob_rdata_a[AW] && cob_rdata_b[AW])
    else $error("pair byte without a cell");

endmodule
